// ===== rtl/core/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the least-run-count thread picker.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int THREAD_SLOTS_DEF = 16;
  localparam int SLOT_W           = 4;
  localparam int COUNT_W          = 32;

  // action codes
  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_SCHED = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_RD,
    S_SCAN,
    S_PICK_RD,
    S_PICK_WR,
    S_OUT
  } lrc_state_t;

  // control from sequencer to the compare unit
  typedef struct packed {
    logic start;     // clear best-so-far
    logic valid;     // an entry is presented this cycle
    logic eligible;  // entry is running and not current
  } lrc_scan_ctl_t;

endpackage

// ===== rtl/core/lrc_in_if.sv =====
// ----------------------------------------------------------------------------
// lrc_in_if
// Request channel: set or schedule transaction.
// ----------------------------------------------------------------------------
interface lrc_in_if import lrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SLOT_W-1:0] slot;
  logic              running;
  logic              clear_count;

  modport source (output valid, action, slot, running, clear_count, input ready);
  modport sink   (input valid, action, slot, running, clear_count, output ready);
endinterface

// ===== rtl/core/lrc_out_if.sv =====
// ----------------------------------------------------------------------------
// lrc_out_if
// Result channel: chosen slot and its run count.
// ----------------------------------------------------------------------------
interface lrc_out_if import lrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  chosen_slot;
  logic [COUNT_W-1:0] chosen_count;
  logic               fell_back;
  logic               was_scheduled;

  modport source (output valid, chosen_slot, chosen_count, fell_back, was_scheduled,
                  input ready);
  modport sink   (input valid, chosen_slot, chosen_count, fell_back, was_scheduled,
                  output ready);
endinterface

// ===== rtl/core/lrc_ram.sv =====
// ----------------------------------------------------------------------------
// lrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lrc_scan.sv =====
// ----------------------------------------------------------------------------
// lrc_scan
// Shared compare unit: tracks the eligible entry with the smallest count,
// later entry wins on a tie.
// ----------------------------------------------------------------------------
module lrc_scan import lrc_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  lrc_scan_ctl_t      ctl,
  input  logic [IDX_W-1:0]   idx,
  input  logic [COUNT_W-1:0] count,
  output logic               found,
  output logic [IDX_W-1:0]   best_idx
);

  logic [COUNT_W-1:0] best_cnt;
  logic               take;

  assign take = ctl.valid && ctl.eligible && (!found || (count <= best_cnt));

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      found    <= 1'b0;
      best_idx <= '0;
    end else if (take) begin
      found    <= 1'b1;
      best_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_cnt <= count;
    end
  end

endmodule

// ===== rtl/core/least_run_count_thread_picker.sv =====
// ----------------------------------------------------------------------------
// least_run_count_thread_picker
// Picks the running thread slot with the smallest run count, other than the
// current one, using one compare unit stepped over the slot table.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------
//  req     | in  | valid/ready  | action, slot, running, clear_count
//  rsp     | out | valid/ready  | chosen_slot, chosen_count, fell_back,
//          |     |              | was_scheduled
//
//  Set transaction: accept, count read, result load.
//  Schedule transaction: the scan reads one count per cycle through the
//  single RAM read port into the compare unit.
//  req.ready is high only while the sequencer is idle; one transaction at a
//  time. A waiting result stalls the sequencer in its result state.
//  Reset (rst, synchronous) clears running flags, count valid bits and the
//  current slot at once; counts read as zero until first written.
// ----------------------------------------------------------------------------
module least_run_count_thread_picker import lrc_pkg::*; #(
  parameter int THREAD_SLOTS = THREAD_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst,
  lrc_in_if.sink   req,
  lrc_out_if.source rsp
);

  localparam int SW = $clog2(THREAD_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(THREAD_SLOTS - 1);

  lrc_state_t state, state_next;

  // slot table control: running flags and count valid bits live in flops
  logic [THREAD_SLOTS-1:0] run_flags;
  logic [THREAD_SLOTS-1:0] cnt_valid;
  logic [SW-1:0]           cur;

  // RAM read address, current and registered
  logic [SW-1:0]      rd_addr, rd_addr_q;
  logic [COUNT_W-1:0] ram_q, cnt_data, cnt_inc;
  logic               ram_we;

  lrc_scan_ctl_t scan_ctl;
  logic          scan_found;
  logic [SW-1:0] scan_best;

  // pending result, loaded into the output register when it frees up
  logic [SLOT_W-1:0]  res_slot;
  logic [COUNT_W-1:0] res_count;
  logic               res_fell;
  logic               res_sched;

  logic          req_fire;
  logic          set_ok;
  logic [SW-1:0] set_idx;
  logic          out_load;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign set_ok    = (32'(req.slot) < 32'(THREAD_SLOTS));
  assign set_idx   = SW'(req.slot);

  // unwritten counts read as zero
  assign cnt_data = cnt_valid[rd_addr_q] ? ram_q : '0;
  assign cnt_inc  = cnt_data + COUNT_W'(1);

  assign out_load = (state == S_OUT) && (!rsp.valid || rsp.ready);

  lrc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (THREAD_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_q),
    .wdata (cnt_inc),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  lrc_scan #(
    .IDX_W (SW)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .idx      (rd_addr_q),
    .count    (cnt_data),
    .found    (scan_found),
    .best_idx (scan_best)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = rd_addr_q;
    ram_we     = 1'b0;
    scan_ctl   = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.action == ACT_SET) begin
            rd_addr    = cur;
            state_next = S_SET_RD;
          end else begin
            rd_addr        = '0;
            scan_ctl.start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SET_RD: begin
        state_next = S_OUT;
      end
      S_SCAN: begin
        // rd_addr_q doubles as the scan index
        scan_ctl.valid    = 1'b1;
        scan_ctl.eligible = run_flags[rd_addr_q] && (rd_addr_q != cur);
        if (rd_addr_q == LAST_IDX) begin
          state_next = S_PICK_RD;
        end else begin
          rd_addr = rd_addr_q + SW'(1);
        end
      end
      S_PICK_RD: begin
        rd_addr    = scan_found ? scan_best : '0;
        state_next = S_PICK_WR;
      end
      S_PICK_WR: begin
        ram_we     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
  end

  // slot table and current slot
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flags <= '0;
      cnt_valid <= '0;
      cur       <= '0;
    end else begin
      if (req_fire && req.action == ACT_SET && set_ok) begin
        run_flags[set_idx] <= req.running;
        if (req.clear_count) begin
          cnt_valid[set_idx] <= 1'b0;
        end
      end
      if (state == S_PICK_RD) begin
        cur <= rd_addr;
      end
      if (state == S_PICK_WR) begin
        cnt_valid[rd_addr_q] <= 1'b1;
      end
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    case (state)
      S_SET_RD: begin
        res_slot  <= SLOT_W'(cur);
        res_count <= cnt_data;
        res_fell  <= 1'b0;
        res_sched <= 1'b0;
      end
      S_PICK_RD: begin
        res_fell <= !scan_found;
      end
      S_PICK_WR: begin
        res_slot  <= SLOT_W'(rd_addr_q);
        res_count <= cnt_inc;
        res_sched <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.chosen_slot   <= res_slot;
      rsp.chosen_count  <= res_count;
      rsp.fell_back     <= res_fell;
      rsp.was_scheduled <= res_sched;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req.ready)
    else $error("request accepted while a transaction was in flight");

  a_pick_is_eligible: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK_RD) && scan_found |-> run_flags[scan_best] && (scan_best != cur))
    else $error("picked slot is not running or is the current slot");

  a_write_to_current: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK_WR) |-> (rd_addr_q == cur))
    else $error("count increment not aimed at the new current slot");

  a_fallback_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.fell_back |-> rsp.was_scheduled && (rsp.chosen_slot == '0))
    else $error("fallback result is not a schedule of slot zero");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the least-run-count thread picker. A scoreboard
// class tracks the slot table, the run counts and the current slot. It works
// out the expected result of every accepted request, then compares each
// result transaction field by field against the oldest pending expectation.
// Directed requests come first, then random traffic that the sender drives
// in bursts. The receiver applies back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lrc_pkg::*;

  localparam int SLOTS        = THREAD_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 4);

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic               fell_back;
    logic               was_scheduled;
  } pick_result_t;

  // Scoreboard: mirrors the slot table and holds the expected picks in order.
  class pick_scoreboard;
    bit                 run_flag[SLOTS];
    bit [COUNT_W-1:0]   run_count[SLOTS];
    bit [SLOT_W-1:0]    current;
    pick_result_t       expected_picks[$];
    int                 mismatches;
    int                 n_set;
    int                 n_sched;
    int                 n_fallback;
    int                 n_checked;

    // Apply one accepted request to the mirror and queue what it should give.
    function void note_request(logic action, logic [SLOT_W-1:0] slot, logic running,
                               logic clear);
      pick_result_t exp;
      int           pick;
      bit           found;
      if (action == ACT_SET) begin
        // slots past the table would be ignored; with 16 slots none exist
        if (int'(slot) < SLOTS) begin
          run_flag[slot] = running;
          if (clear) run_count[slot] = '0;
        end
        exp.slot          = current;
        exp.count         = run_count[current];
        exp.fell_back     = 1'b0;
        exp.was_scheduled = 1'b0;
        n_set++;
      end else begin
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (i == int'(current) || !run_flag[i]) continue;
          // <= lets the later slot win a tie
          if (!found || run_count[i] <= run_count[pick]) begin
            pick  = i;
            found = 1'b1;
          end
        end
        // fallback: slot 0, whatever its flag and even if current
        if (!found) pick = 0;
        run_count[pick]   = run_count[pick] + 1'b1;
        current           = SLOT_W'(pick);
        exp.slot          = SLOT_W'(pick);
        exp.count         = run_count[pick];
        exp.fell_back     = !found;
        exp.was_scheduled = 1'b1;
        n_sched++;
        if (!found) n_fallback++;
      end
      expected_picks.push_back(exp);
    endfunction

    function void report(string field, logic [COUNT_W-1:0] exp, logic [COUNT_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, got);
    endfunction

    function void check_result(pick_result_t got);
      pick_result_t exp;
      if (expected_picks.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, expected none, actual slot %0h count %0h",
                 $time, got.slot, got.count);
        return;
      end
      exp = expected_picks.pop_front();
      n_checked++;
      if (got.slot !== exp.slot)
        report("chosen_slot", COUNT_W'(exp.slot), COUNT_W'(got.slot));
      if (got.count !== exp.count) report("chosen_count", exp.count, got.count);
      if (got.fell_back !== exp.fell_back)
        report("fell_back", COUNT_W'(exp.fell_back), COUNT_W'(got.fell_back));
      if (got.was_scheduled !== exp.was_scheduled)
        report("was_scheduled", COUNT_W'(exp.was_scheduled), COUNT_W'(got.was_scheduled));
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   stall_left;

  lrc_in_if  req ();
  lrc_out_if rsp ();

  pick_scoreboard sb;

  least_run_count_thread_picker #(
    .THREAD_SLOTS(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycles,
               sb.pending());
      $display("least_run_count_thread_picker test failed");
      $finish;
    end
  end

  // Monitor: results are checked before the same edge's request is noted, so
  // a result can never be matched against an expectation queued at its own edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        sb.check_result(pick_result_t'{slot: rsp.chosen_slot, count: rsp.chosen_count,
                                       fell_back: rsp.fell_back,
                                       was_scheduled: rsp.was_scheduled});
      if (req.valid && req.ready)
        sb.note_request(req.action, req.slot, req.running, req.clear_count);
    end
  end

  // Receiver back-pressure. The mode rotates between always ready, short
  // frequent stalls and long occasional stalls.
  initial begin
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        case ((cycles / 2000) % 3)
          1: begin
            if ($urandom_range(0, 99) < 30) stall_left = $urandom_range(1, 4);
          end
          2: begin
            if ($urandom_range(0, 99) < 10) stall_left = $urandom_range(5, 24);
          end
          default: stall_left = 0;
        endcase
        rsp.ready <= (stall_left == 0);
      end
    end
  end

  // Present one request and hold it until the handshake completes. valid stays
  // high on return so that back-to-back transactions need no extra step.
  task automatic send_request(logic action, logic [SLOT_W-1:0] slot, logic running,
                              logic clear);
    req.valid       <= 1'b1;
    req.action      <= action;
    req.slot        <= slot;
    req.running     <= running;
    req.clear_count <= clear;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic set_slot(logic [SLOT_W-1:0] slot, logic running, logic clear);
    send_request(ACT_SET, slot, running, clear);
  endtask

  task automatic schedule_tick();
    send_request(ACT_SCHED, SLOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic sender_gap(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold the sender off until every expected result has been seen.
  task automatic wait_all_done();
    req.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    schedule_tick();              // nothing running: fallback to slot 0
    schedule_tick();              // fallback again, slot 0 already current
    set_slot(4'd0, 1'b1, 1'b0);
    schedule_tick();              // only the current slot runs: fallback
    set_slot(4'd15, 1'b1, 1'b0);
    schedule_tick();              // picks 15
    schedule_tick();              // back to 0, current 15 excluded
    set_slot(4'd0, 1'b1, 1'b1);   // clear the current slot's count
    set_slot(4'd5, 1'b1, 1'b1);
    set_slot(4'd9, 1'b1, 1'b1);
    schedule_tick();              // tie between 5 and 9: later wins
    schedule_tick();
    schedule_tick();
    set_slot(4'd15, 1'b0, 1'b1);  // stop and clear
    set_slot(4'd5, 1'b0, 1'b0);   // stop, keep count
    schedule_tick();
    set_slot(4'd10, 1'b1, 1'b0);
    set_slot(4'd3, 1'b1, 1'b1);
    schedule_tick();
    schedule_tick();
    set_slot(4'd0, 1'b0, 1'b1);
    set_slot(4'd9, 1'b0, 1'b1);
    set_slot(4'd10, 1'b0, 1'b1);
    set_slot(4'd3, 1'b0, 1'b1);
    schedule_tick();              // table empty: fallback
    wait_all_done();
  endtask

  // Mostly meaningful traffic: sets with runnable bias and schedule ticks.
  // Every few hundred items the runnable bias drops so the table drains and
  // the fallback path is exercised.
  task automatic run_random(int n);
    int  burst_left;
    int  run_pct;
    bit  no_gaps;
    burst_left = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      if (k > 0 && k % 300 == 0) wait_all_done();
      run_pct = ((k / 150) % 4 == 3) ? 10 : 70;
      no_gaps = (k >= 600 && k < 800);
      if ($urandom_range(0, 99) < 35)
        schedule_tick();
      else
        set_slot(SLOT_W'($urandom_range(0, 15)), $urandom_range(0, 99) < run_pct,
                 $urandom_range(0, 99) < 15);
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        if (!no_gaps) sender_gap($urandom_range(1, 30));
      end
    end
    req.valid <= 1'b0;
  endtask

  initial begin
    sb     = new;
    cycles = 0;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.action      <= ACT_SET;
    req.slot        <= '0;
    req.running     <= 1'b0;
    req.clear_count <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(RANDOM_ITEMS);

    // step past the last accepting edge so its expectation is already queued
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d set and %0d schedule transactions, %0d of them fallbacks",
             sb.n_set, sb.n_sched, sb.n_fallback);
    $display("checked %0d results, %0d mismatches", sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("least_run_count_thread_picker test passed");
    end else begin
      $display("least_run_count_thread_picker test failed");
    end
    $finish;
  end

endmodule
